// ===== rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes and controller/datapath types of the bitmap frame
// allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // frame geometry; frame size is a power of two
    localparam int unsigned FRAME_BYTES = 4096;
    localparam int unsigned FRAME_COUNT = 32768;
    localparam int unsigned FB_BITS     = $clog2(FRAME_BYTES);

    // bitmap words of 32 frames each
    localparam int unsigned WORDS = (FRAME_COUNT + 31) / 32;
    localparam int unsigned WI_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

    // used counter width, wide enough for the full frame count
    localparam int unsigned CW = $clog2(FRAME_COUNT + 1);

    // byte arithmetic width: holds address + length and the memory end
    localparam int unsigned FC_BITS = $clog2(FRAME_COUNT + 1);
    localparam int unsigned BW      = (FC_BITS + FB_BITS > 33) ? FC_BITS + FB_BITS : 33;
    // frame index width
    localparam int unsigned FW      = BW - FB_BITS;

    localparam logic [BW-1:0] MEM_END   = BW'(FRAME_COUNT) << FB_BITS;
    localparam int unsigned   LOW_RES   = (1024 * 1024) / FRAME_BYTES;
    localparam logic [31:0]   ALL_ONES  = 32'hFFFF_FFFF;

    // operations
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_RESERVE = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_IGNORED = 2'd2
    } t_stat;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_END,
        ST_BOUNDS,
        ST_START,
        ST_RUN,
        ST_RESULT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic calc_end;
        logic calc_bounds;
        logic run_start;
        logic load_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic run_done;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/bfa_in_if.sv =====
// ----------------------------------------------------------------------------
// bfa_in_if
// Request channel of the frame allocator: operation, address and length.
// ----------------------------------------------------------------------------
interface bfa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] address;
    logic [31:0] length;

    modport source (output valid, output op, output address, output length, input ready);
    modport sink   (input valid, input op, input address, input length, output ready);
endinterface

// ===== rtl/bfa_out_if.sv =====
// ----------------------------------------------------------------------------
// bfa_out_if
// Result channel of the frame allocator: frame address, status and counts.
// ----------------------------------------------------------------------------
interface bfa_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_address;
    logic [1:0]  status;
    logic [15:0] used_count;
    logic [15:0] free_count;

    modport source (output valid, output frame_address, output status,
                    output used_count, output free_count, input ready);
    modport sink   (input valid, input frame_address, input status,
                    input used_count, input free_count, output ready);
endinterface

// ===== rtl/bitmap_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Physical frame allocator with one used bit per frame, all frames used
// after reset, serving allocate, free, release range and reserve range items.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass (one bitmap word per cycle) that
// marks every frame used; no item is taken until it ends. Items are then
// handled one at a time: an item that walks the bitmap reads the 32-frame
// bitmap words it touches one word per cycle through the single read port of
// the bitmap memory with a read-modify-write pipeline. A free touches one
// word, a range touches the words it spans, and an allocate walks from word 0
// up to the first word with a free frame (at most 1024 words). An ignored
// item, or a release range with no whole frame inside, skips the walk. A new
// item is taken while the previous result still waits in the output
// register; a finished result waits for that register to drain.
module bitmap_frame_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfa_in_if.sink     i_in,
    bfa_out_if.source  o_out
);

    bfa_pkg::t_cmd cmd;
    bfa_pkg::t_sts sts;

    // sequencer
    bfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // bitmap, counters and result register
    bfa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_op            (i_in.op),
        .i_address       (i_in.address),
        .i_length        (i_in.length),
        .i_ready         (o_out.ready),
        .o_valid         (o_out.valid),
        .o_frame_address (o_out.frame_address),
        .o_status        (o_out.status),
        .o_used_count    (o_out.used_count),
        .o_free_count    (o_out.free_count)
    );

endmodule

// ===== rtl/bfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer of the frame allocator: clearing pass after reset, then per item
// end clamp, bound calculation, bitmap walk and result hand-off.
// ----------------------------------------------------------------------------
module bfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  bfa_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output bfa_pkg::t_cmd o_cmd
);

    bfa_pkg::t_state r_state;
    bfa_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfa_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bfa_pkg::ST_CLEAR: begin
                if (i_sts.clear_last) n_state = bfa_pkg::ST_IDLE;
            end
            bfa_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = bfa_pkg::ST_END;
            end
            bfa_pkg::ST_END:    n_state = bfa_pkg::ST_BOUNDS;
            bfa_pkg::ST_BOUNDS: n_state = bfa_pkg::ST_START;
            bfa_pkg::ST_START:  n_state = bfa_pkg::ST_RUN;
            bfa_pkg::ST_RUN: begin
                if (i_sts.run_done) n_state = bfa_pkg::ST_RESULT;
            end
            bfa_pkg::ST_RESULT: begin
                if (i_sts.out_free) n_state = bfa_pkg::ST_IDLE;
            end
            default: n_state = bfa_pkg::ST_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            bfa_pkg::ST_CLEAR:  o_cmd.clear_en = 1'b1;
            bfa_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            bfa_pkg::ST_END:    o_cmd.calc_end    = 1'b1;
            bfa_pkg::ST_BOUNDS: o_cmd.calc_bounds = 1'b1;
            bfa_pkg::ST_START:  o_cmd.run_start   = 1'b1;
            bfa_pkg::ST_RUN:    o_cmd             = '0;
            bfa_pkg::ST_RESULT: o_cmd.load_out    = i_sts.out_free;
            default:            o_cmd             = '0;
        endcase
    end

endmodule

// ===== rtl/bfa_dp.sv =====
// ----------------------------------------------------------------------------
// bfa_dp
// Datapath of the frame allocator: item registers, range clamp, bitmap
// memory with a read-modify-write walk of one word per cycle, used counter
// and result register.
// ----------------------------------------------------------------------------
module bfa_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bfa_pkg::t_cmd i_cmd,
    output bfa_pkg::t_sts o_sts,
    input  logic [1:0]    i_op,
    input  logic [31:0]   i_address,
    input  logic [31:0]   i_length,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [31:0]   o_frame_address,
    output logic [1:0]    o_status,
    output logic [15:0]   o_used_count,
    output logic [15:0]   o_free_count
);

    localparam int unsigned BW   = bfa_pkg::BW;
    localparam int unsigned FW   = bfa_pkg::FW;
    localparam int unsigned WI_W = bfa_pkg::WI_W;
    localparam int unsigned CW   = bfa_pkg::CW;
    localparam int unsigned FBB  = bfa_pkg::FB_BITS;

    // item registers
    bfa_pkg::t_op  r_op;
    logic [31:0]   r_addr;
    logic [31:0]   r_len;
    logic [BW-1:0] r_end;
    logic          r_ign;
    logic [FW-1:0] r_first;
    logic [FW-1:0] r_last;

    // walk registers
    logic            r_rd_active;
    logic            r_stop;
    logic [WI_W-1:0] r_rd_w;
    logic [WI_W-1:0] r_fw;
    logic [WI_W-1:0] r_lw;
    logic [4:0]      r_lo;
    logic [4:0]      r_hi;
    logic            r_b_valid;
    logic [WI_W-1:0] r_b_w;
    logic [31:0]     r_rdata;
    logic            r_c_valid;
    logic [5:0]      r_delta;
    logic [CW-1:0]   r_used;
    logic [31:0]     r_fa;
    bfa_pkg::t_stat  r_status;
    logic [WI_W-1:0] r_clr_idx;

    // result register
    logic        r_o_valid;
    logic [31:0] r_o_fa;
    logic [1:0]  r_o_status;
    logic [15:0] r_o_used;
    logic [15:0] r_o_free;

    // bitmap memory
    logic [31:0] mem [bfa_pkg::WORDS];

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= bfa_pkg::t_op'(i_op);
            r_addr <= i_address;
            r_len  <= i_length;
        end
    end

    // range end clamp and rejection checks
    logic [32:0]       sum_end;
    logic [BW-1:0]     end_raw;
    logic [BW-1:0]     end_cl;
    logic [BW-1:0]     addr_ext;
    logic [31-FBB:0]   free_f;
    logic              ign_free;
    logic              ign_range;
    logic              ign;

    always_comb begin
        sum_end   = {1'b0, r_addr} + {1'b0, r_len};
        end_raw   = sum_end[32] ? bfa_pkg::MEM_END : BW'(sum_end);
        end_cl    = (end_raw > bfa_pkg::MEM_END) ? bfa_pkg::MEM_END : end_raw;
        addr_ext  = BW'(r_addr);
        free_f    = r_addr[31:FBB];
        ign_free  = (r_addr == bfa_pkg::ALL_ONES) || (r_addr[FBB-1:0] != '0) ||
                    (BW'(free_f) >= BW'(bfa_pkg::FRAME_COUNT)) ||
                    (BW'(free_f) < BW'(bfa_pkg::LOW_RES));
        ign_range = (r_len == '0) || (addr_ext >= bfa_pkg::MEM_END);
        case (r_op)
            bfa_pkg::OP_ALLOC: ign = 1'b0;
            bfa_pkg::OP_FREE:  ign = ign_free;
            default:           ign = ign_range;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_end) begin
            r_end <= end_cl;
            r_ign <= ign;
        end
    end

    // frame bounds, release rounds inward and reserve outward
    logic [BW-1:0] addr_up;
    logic [BW-1:0] end_up;
    logic [FW-1:0] a_dn;
    logic [FW-1:0] a_up;
    logic [FW-1:0] e_dn;
    logic [FW-1:0] e_up;
    logic [FW-1:0] fc_f;
    logic [FW-1:0] first_n;
    logic [FW-1:0] last_n;

    always_comb begin
        addr_up = addr_ext + BW'(bfa_pkg::FRAME_BYTES - 1);
        end_up  = r_end + BW'(bfa_pkg::FRAME_BYTES - 1);
        a_dn    = addr_ext[BW-1:FBB];
        a_up    = addr_up[BW-1:FBB];
        e_dn    = r_end[BW-1:FBB];
        e_up    = end_up[BW-1:FBB];
        fc_f    = FW'(bfa_pkg::FRAME_COUNT);
        case (r_op)
            bfa_pkg::OP_ALLOC: begin
                first_n = '0;
                last_n  = fc_f;
            end
            bfa_pkg::OP_FREE: begin
                first_n = a_dn;
                last_n  = a_dn + FW'(1);
            end
            bfa_pkg::OP_RELEASE: begin
                first_n = a_up;
                last_n  = (e_dn > fc_f) ? fc_f : e_dn;
            end
            bfa_pkg::OP_RESERVE: begin
                first_n = a_dn;
                last_n  = (e_up > fc_f) ? fc_f : e_up;
            end
            default: begin
                first_n = '0;
                last_n  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_bounds) begin
            r_first <= first_n;
            r_last  <= last_n;
        end
    end

    // walk setup
    logic [FW-1:0] last_m1;
    logic          run_empty;

    assign last_m1   = r_last - FW'(1);
    assign run_empty = r_ign || (r_first >= r_last);

    // word modify stage: mask, lowest free bit, changed bit count
    logic [31:0] lo_mask;
    logic [31:0] hi_mask;
    logic [31:0] mask;
    logic [31:0] zero_oh;
    logic [4:0]  zero_idx;
    logic        found;
    logic [31:0] new_word;
    logic [31:0] diff;
    logic [1:0]  p1 [16];
    logic [2:0]  p2 [8];
    logic [3:0]  p3 [4];
    logic [4:0]  p4 [2];
    logic [5:0]  pop;
    logic        b_live;
    logic        rd_en;
    logic [WI_W+5+FBB-1:0] fa_wide;

    assign rd_en  = r_rd_active && !r_stop;
    assign b_live = r_b_valid && !r_stop;

    always_comb begin
        lo_mask  = (r_b_w == r_fw) ? (32'hFFFF_FFFF << r_lo) : 32'hFFFF_FFFF;
        hi_mask  = (r_b_w == r_lw) ? (32'hFFFF_FFFF >> (5'd31 - r_hi)) : 32'hFFFF_FFFF;
        mask     = lo_mask & hi_mask;
        zero_oh  = ~r_rdata & (r_rdata + 32'd1);
        found    = |zero_oh;
        zero_idx = '0;
        for (int i = 0; i < 32; i++) begin
            if (zero_oh[i]) zero_idx = zero_idx | 5'(i);
        end
        case (r_op)
            bfa_pkg::OP_ALLOC:                    new_word = r_rdata | zero_oh;
            bfa_pkg::OP_FREE, bfa_pkg::OP_RELEASE: new_word = r_rdata & ~mask;
            bfa_pkg::OP_RESERVE:                  new_word = r_rdata | mask;
            default:                              new_word = r_rdata;
        endcase
        diff = new_word ^ r_rdata;
        for (int i = 0; i < 16; i++) p1[i] = {1'b0, diff[2*i]} + {1'b0, diff[2*i+1]};
        for (int i = 0; i < 8; i++)  p2[i] = {1'b0, p1[2*i]} + {1'b0, p1[2*i+1]};
        for (int i = 0; i < 4; i++)  p3[i] = {1'b0, p2[2*i]} + {1'b0, p2[2*i+1]};
        for (int i = 0; i < 2; i++)  p4[i] = {1'b0, p3[2*i]} + {1'b0, p3[2*i+1]};
        pop     = {1'b0, p4[0]} + {1'b0, p4[1]};
        fa_wide = {r_b_w, zero_idx, {FBB{1'b0}}};
    end

    // memory write port shared by the clearing pass and the walk
    logic            we;
    logic [WI_W-1:0] waddr;
    logic [31:0]     wdata;

    assign we    = i_cmd.clear_en || b_live;
    assign waddr = i_cmd.clear_en ? r_clr_idx : r_b_w;
    assign wdata = i_cmd.clear_en ? 32'hFFFF_FFFF : new_word;

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (rd_en) r_rdata <= mem[r_rd_w];
    end

    // walk control and used counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_active <= 1'b0;
            r_stop      <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_used      <= CW'(bfa_pkg::FRAME_COUNT);
            r_clr_idx   <= '0;
        end else begin
            if (i_cmd.clear_en) r_clr_idx <= r_clr_idx + WI_W'(1);
            if (i_cmd.run_start) begin
                r_rd_active <= !run_empty;
                r_stop      <= 1'b0;
                r_b_valid   <= 1'b0;
                r_c_valid   <= 1'b0;
            end else begin
                r_b_valid <= rd_en;
                r_c_valid <= b_live;
                if (rd_en && (r_rd_w == r_lw)) r_rd_active <= 1'b0;
                if (b_live && (r_op == bfa_pkg::OP_ALLOC) && found) begin
                    r_stop      <= 1'b1;
                    r_rd_active <= 1'b0;
                end
            end
            // apply the changed bit count, never below zero
            if (r_c_valid) begin
                if ((r_op == bfa_pkg::OP_ALLOC) || (r_op == bfa_pkg::OP_RESERVE)) begin
                    r_used <= r_used + CW'(r_delta);
                end else if (r_used >= CW'(r_delta)) begin
                    r_used <= r_used - CW'(r_delta);
                end else begin
                    r_used <= '0;
                end
            end
        end
    end

    // walk payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start) begin
            r_rd_w <= r_first[WI_W+4:5];
            r_fw   <= r_first[WI_W+4:5];
            r_lo   <= r_first[4:0];
            r_lw   <= last_m1[WI_W+4:5];
            r_hi   <= last_m1[4:0];
            r_fa   <= bfa_pkg::ALL_ONES;
            if (r_ign) begin
                r_status <= bfa_pkg::STAT_IGNORED;
            end else if (r_op == bfa_pkg::OP_ALLOC) begin
                r_status <= bfa_pkg::STAT_NO_FREE;
            end else begin
                r_status <= bfa_pkg::STAT_DONE;
            end
        end else begin
            if (rd_en) begin
                r_rd_w <= r_rd_w + WI_W'(1);
                r_b_w  <= r_rd_w;
            end
            if (b_live) r_delta <= pop;
            if (b_live && (r_op == bfa_pkg::OP_ALLOC) && found) begin
                r_fa     <= 32'(fa_wide);
                r_status <= bfa_pkg::STAT_DONE;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_fa     <= r_fa;
            r_o_status <= r_status;
            r_o_used   <= 16'(r_used);
            r_o_free   <= 16'(CW'(bfa_pkg::FRAME_COUNT) - r_used);
        end
    end

    // status to the controller
    always_comb begin
        o_sts.clear_last = i_cmd.clear_en && (r_clr_idx == WI_W'(bfa_pkg::WORDS - 1));
        o_sts.run_done   = !r_rd_active && !r_b_valid && !r_c_valid;
        o_sts.out_free   = !r_o_valid || i_ready;
    end

    assign o_valid         = r_o_valid;
    assign o_frame_address = r_o_fa;
    assign o_status        = r_o_status;
    assign o_used_count    = r_o_used;
    assign o_free_count    = r_o_free;

    // clearing pass and the walk never write in the same cycle
    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clear_en && b_live))
        else $error("clearing pass and bitmap walk write together");

    // an allocation hit leaves a real frame address and a done status
    a_alloc_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_stop) |-> (r_op == bfa_pkg::OP_ALLOC) && (r_status == bfa_pkg::STAT_DONE) &&
                          (r_fa != bfa_pkg::ALL_ONES))
        else $error("allocation stop without a found frame");

    // frames cleared never outnumber frames counted as used
    a_used_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && ((r_op == bfa_pkg::OP_FREE) || (r_op == bfa_pkg::OP_RELEASE))
        |-> r_used >= CW'(r_delta))
        else $error("used counter out of step with bitmap");

    // result load only into a free result register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_o_valid || i_ready))
        else $error("result register overwritten");

    // used counter bounded by the frame count
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(bfa_pkg::FRAME_COUNT))
        else $error("used counter above frame count");

endmodule
